>>> hdl/triangle_bbox_edge_rasterizer_top_assert.svh
// Assertion macros for the triangle rasteriser top level.
// Needs clk and rst in scope at the point of use.
`ifndef TRIANGLE_BBOX_EDGE_RASTERIZER_TOP_ASSERT_SVH
`define TRIANGLE_BBOX_EDGE_RASTERIZER_TOP_ASSERT_SVH

// same-cycle implication
`define TBR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tbr_pkg.sv
// Shared constants, types and opcodes for the triangle rasteriser.
// No dependencies; every other file but the assert header imports it.
package tbr_pkg;

  localparam int COORD_BITS    = 12;
  localparam int PIX_BITS      = 11;
  localparam int DIM_BITS      = 12;
  localparam int COLOR_BITS    = 32;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;
  localparam int REG_SEL_BIT   = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [PIX_BITS-1:0]          pix_t;
  typedef logic [DIM_BITS-1:0]          dim_t;
  typedef logic [COLOR_BITS-1:0]        color_t;

  localparam dim_t DIM_MAX             = DIM_BITS'(2048);
  localparam dim_t IMAGE_WIDTH_RESET   = DIM_BITS'(800);
  localparam dim_t IMAGE_HEIGHT_RESET  = DIM_BITS'(500);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } vert_t;

  typedef struct packed {
    pix_t min_x;
    pix_t min_y;
    pix_t max_x;
    pix_t max_y;
  } box_t;

endpackage

>>> hdl/tbr_cmd_if.sv
// Command channel: load or step words with vertex and colour payload.
// Depends on tbr_pkg.
interface tbr_cmd_if import tbr_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   opcode;
  coord_t vertex0_x;
  coord_t vertex0_y;
  coord_t vertex1_x;
  coord_t vertex1_y;
  coord_t vertex2_x;
  coord_t vertex2_y;
  color_t fill_color;

  modport source (
    output valid, opcode, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
           vertex2_x, vertex2_y, fill_color,
    input  ready
  );
  modport sink (
    input  valid, opcode, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
           vertex2_x, vertex2_y, fill_color,
    output ready
  );
endinterface

>>> hdl/tbr_pix_if.sv
// Pixel channel: one word per visited bounding box position.
// Depends on tbr_pkg.
interface tbr_pix_if import tbr_pkg::*; ();
  logic   valid;
  logic   ready;
  pix_t   pixel_x;
  pix_t   pixel_y;
  logic   covered;
  color_t pixel_color;
  logic   last;

  modport source (
    output valid, pixel_x, pixel_y, covered, pixel_color, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, covered, pixel_color, last,
    output ready
  );
endinterface

>>> hdl/triangle_bbox_edge_rasterizer_top.sv
// Triangle rasteriser top level: APB size registers, scan state, output register.
// Depends on tbr_pkg, tbr_cmd_if, tbr_pix_if, tbr_bbox, tbr_edge and the assert header.
//
// A load word (opcode 0) takes three vertices and a colour, computes the clipped
// bounding box and arms the scan, and returns nothing. Each step word (opcode 1)
// visits the next box position, x outer and y inner, and returns one registered
// pixel word that carries the position, the covered flag, the colour
// and last on the final position; a step with no triangle armed is swallowed.
// One command word is taken every clock: the inside test (six 13x13 multiplies and
// the sign checks) sits between the scan registers and the output register, and
// cmd.ready stays high while the output register is empty or being drained.
// Width and height registers lie at byte addresses 0 and 4; write them while idle.
`include "triangle_bbox_edge_rasterizer_top_assert.svh"

module triangle_bbox_edge_rasterizer_top import tbr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  tbr_cmd_if.sink                  cmd,
  tbr_pix_if.source                pix
);

  dim_t   image_width;
  dim_t   image_height;
  vert_t  vert;
  box_t   box;
  box_t   box_new;
  vert_t  vert_in;
  pix_t   scan_x;
  pix_t   scan_y;
  color_t held_color;
  logic   active;

  logic   pix_valid;
  pix_t   pix_x;
  pix_t   pix_y;
  logic   pix_cov;
  color_t pix_color;
  logic   pix_last;

  logic   cmd_acc;
  logic   load;
  logic   step;
  logic   fin;
  logic   covered_now;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[REG_SEL_BIT])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[DIM_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_SEL_BIT])
      REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(image_height);
      default:          prdata = '0;
    endcase
  end

  // command handshake
  assign cmd.ready = !pix_valid || pix.ready;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign load      = cmd_acc && (cmd.opcode == OP_LOAD);
  assign step      = cmd_acc && (cmd.opcode == OP_STEP) && active;
  assign fin       = (scan_x >= box.max_x) && (scan_y >= box.max_y);

  assign vert_in.x0 = cmd.vertex0_x;
  assign vert_in.y0 = cmd.vertex0_y;
  assign vert_in.x1 = cmd.vertex1_x;
  assign vert_in.y1 = cmd.vertex1_y;
  assign vert_in.x2 = cmd.vertex2_x;
  assign vert_in.y2 = cmd.vertex2_y;

  tbr_bbox u_bbox (
    .verts        (vert_in),
    .image_width  (image_width),
    .image_height (image_height),
    .box          (box_new)
  );

  tbr_edge u_edge (
    .verts   (vert),
    .px      (scan_x),
    .py      (scan_y),
    .covered (covered_now)
  );

  // triangle and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (step && fin) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vert       <= vert_in;
      box        <= box_new;
      held_color <= cmd.fill_color;
      scan_x     <= box_new.min_x;
      scan_y     <= box_new.min_y;
    end else if (step && !fin) begin
      if (scan_y < box.max_y) begin
        scan_y <= scan_y + PIX_BITS'(1);
      end else begin
        // wrap to the top of the next column
        scan_y <= box.min_y;
        scan_x <= scan_x + PIX_BITS'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (step) begin
      pix_valid <= 1'b1;
    end else if (pix.ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pix_x     <= scan_x;
      pix_y     <= scan_y;
      pix_cov   <= covered_now;
      pix_color <= held_color;
      pix_last  <= fin;
    end
  end

  assign pix.valid       = pix_valid;
  assign pix.pixel_x     = pix_x;
  assign pix.pixel_y     = pix_y;
  assign pix.covered     = pix_cov;
  assign pix.pixel_color = pix_color;
  assign pix.last        = pix_last;

  `TBR_ASSERT_NXT(a_load_arms_scan, load,
    active && (scan_x == box.min_x) && (scan_y == box.min_y),
    "load did not arm the scan at the box corner")

  `TBR_ASSERT_NXT(a_last_drops_active, step && fin,
    !active && pix_valid && pix_last,
    "final box position did not end the scan with last set")

  `TBR_ASSERT_IMP(a_scan_in_box, active,
    (scan_x >= box.min_x) && (scan_x <= box.max_x) &&
    (scan_y >= box.min_y) && (scan_y <= box.max_y),
    "scan position left the bounding box")

endmodule

>>> hdl/tbr_bbox.sv
// Bounding box of three vertices, clipped to the image size registers.
// Depends on tbr_pkg.
module tbr_bbox import tbr_pkg::*; (
  input  vert_t verts,
  input  dim_t  image_width,
  input  dim_t  image_height,
  output box_t  box
);

  localparam int BW = ((COORD_BITS > PIX_BITS) ? COORD_BITS : PIX_BITS) + 1;
  typedef logic signed [BW-1:0] bval_t;

  // out-of-range sizes: 0 acts as 1, anything above the maximum as the maximum
  function automatic pix_t dim_cap(input dim_t r);
    dim_t d;
    d = r;
    if (d == '0) d = DIM_BITS'(1);
    if (d > DIM_MAX) d = DIM_MAX;
    return PIX_BITS'(d - DIM_BITS'(1));
  endfunction

  function automatic bval_t smin(input bval_t a, input bval_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic bval_t smax(input bval_t a, input bval_t b);
    return (a > b) ? a : b;
  endfunction

  bval_t vx0, vy0, vx1, vy1, vx2, vy2;
  bval_t cx, cy;
  bval_t mnx, mny, mxx, mxy;

  assign vx0 = BW'(verts.x0);
  assign vy0 = BW'(verts.y0);
  assign vx1 = BW'(verts.x1);
  assign vy1 = BW'(verts.y1);
  assign vx2 = BW'(verts.x2);
  assign vy2 = BW'(verts.y2);

  assign cx = BW'(signed'({1'b0, dim_cap(image_width)}));
  assign cy = BW'(signed'({1'b0, dim_cap(image_height)}));

  // floor both the minimum and the maximum at 0, cap both at the image edge
  assign mnx = smax('0, smin(smin(cx, vx0), smin(vx1, vx2)));
  assign mny = smax('0, smin(smin(cy, vy0), smin(vy1, vy2)));
  assign mxx = smin(cx, smax(smax('0, vx0), smax(vx1, vx2)));
  assign mxy = smin(cy, smax(smax('0, vy0), smax(vy1, vy2)));

  assign box.min_x = PIX_BITS'(mnx);
  assign box.min_y = PIX_BITS'(mny);
  assign box.max_x = PIX_BITS'(mxx);
  assign box.max_y = PIX_BITS'(mxy);

endmodule

>>> hdl/tbr_edge.sv
// Exact integer inside test of one position against the held triangle.
// Depends on tbr_pkg.
module tbr_edge import tbr_pkg::*; (
  input  vert_t verts,
  input  pix_t  px,
  input  pix_t  py,
  output logic  covered
);

  localparam int EW = ((COORD_BITS > PIX_BITS + 1) ? COORD_BITS : PIX_BITS + 1) + 1;
  localparam int PW = 2 * EW;
  localparam int CW = PW + 1;
  localparam int FW = CW + 2;

  logic signed [EW-1:0] ax, ay, az, bx, by, bz;
  logic signed [PW-1:0] p_ay_bz, p_az_by, p_az_bx, p_ax_bz, p_ax_by, p_ay_bx;
  logic signed [CW-1:0] ux, uy, uz;
  logic signed [FW-1:0] uw;
  logic                 neg;
  logic                 ok_x, ok_y, ok_w;

  assign ax = EW'(verts.x2) - EW'(verts.x0);
  assign ay = EW'(verts.x1) - EW'(verts.x0);
  assign az = EW'(verts.x0) - EW'(signed'({1'b0, px}));
  assign bx = EW'(verts.y2) - EW'(verts.y0);
  assign by = EW'(verts.y1) - EW'(verts.y0);
  assign bz = EW'(verts.y0) - EW'(signed'({1'b0, py}));

  assign p_ay_bz = ay * bz;
  assign p_az_by = az * by;
  assign p_az_bx = az * bx;
  assign p_ax_bz = ax * bz;
  assign p_ax_by = ax * by;
  assign p_ay_bx = ay * bx;

  assign ux = CW'(p_ay_bz) - CW'(p_az_by);
  assign uy = CW'(p_az_bx) - CW'(p_ax_bz);
  assign uz = CW'(p_ax_by) - CW'(p_ay_bx);
  assign uw = FW'(uz) - FW'(ux) - FW'(uy);

  // a term agrees when it is zero or carries the sign of uz
  assign neg  = uz[CW-1];
  assign ok_x = (ux == '0) || (ux[CW-1] == neg);
  assign ok_y = (uy == '0) || (uy[CW-1] == neg);
  assign ok_w = (uw == '0) || (uw[FW-1] == neg);

  // degenerate triangle covers nothing
  assign covered = (uz != '0) && ok_x && ok_y && ok_w;

endmodule
